>>> design/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants of the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int MaxItems = 64;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CountW   = $clog2(MaxItems + 1);

    // register index, taken from paddr[2]
    localparam logic RegSortAscending = 1'b0;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               last_item;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_flag;
        logic               truncated;
    } out_word_t;

    typedef struct packed {
        in_word_t item;
        logic     ascending;
    } job_t;

endpackage

>>> design/ise_front.sv
// ----------------------------------------------------------------------------
// ise_front
// Input side: takes words, tags them with the sort direction and queues them.
// ----------------------------------------------------------------------------
module ise_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ise_pkg::in_word_t in_word,
    input  logic             sort_ascending,
    output logic             job_valid,
    input  logic             job_take,
    output ise_pkg::job_t    job
);

    ise_pkg::job_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_stall  = (fill_reg == 2'd2);
    assign job_valid = (fill_reg != 2'd0);
    assign job       = entries_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = job_take && job_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg].item      <= in_word;
            entries_reg[wr_ptr_reg].ascending <= sort_ascending;
        end
    end

endmodule

>>> design/ise_back.sv
// ----------------------------------------------------------------------------
// ise_back
// Sort store and sequencer: inserts queued values, streams out finished runs.
// ----------------------------------------------------------------------------
module ise_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_take,
    input  ise_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_stall,
    output ise_pkg::out_word_t out_word
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SHIFT   = 5'b00010,
        ST_PLACE   = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_LD = 5'b10000
    } state_t;

    localparam int IdxW   = ise_pkg::IdxW;
    localparam int CountW = ise_pkg::CountW;

    logic signed [31:0] store [ise_pkg::MaxItems];
    logic signed [31:0] rdata_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   count_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [IdxW-1:0]     j_reg;
    logic [IdxW-1:0]     j_next;
    logic [IdxW-1:0]     k_reg;
    logic [IdxW-1:0]     k_next;
    ise_pkg::job_t       key_reg;
    ise_pkg::job_t       key_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    ise_pkg::out_word_t  out_word_reg;
    ise_pkg::out_word_t  out_word_next;

    logic                mem_we;
    logic [IdxW-1:0]     mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic [IdxW-1:0]     rd_addr;
    logic                out_free;
    logic                move;
    logic                is_final;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign move      = key_reg.ascending ? (rdata_reg > key_reg.item.item_value)
                                         : (key_reg.item.item_value > rdata_reg);
    assign is_final  = (CountW'(k_reg) + CountW'(1)) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        mem_we         = 1'b0;
        mem_waddr      = j_reg;
        mem_wdata      = key_reg.item.item_value;
        rd_addr        = k_reg;
        job_take       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    key_next = job;
                    k_next   = '0;
                    if (count_reg >= CountW'(ise_pkg::MaxItems))
                    begin
                        // drop
                        ovf_next = 1'b1;
                        if (job.item.last_item)
                            state_next = ST_EMIT_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = job.item.item_value;
                        count_next = CountW'(1);
                        if (job.item.last_item)
                            state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        rd_addr    = IdxW'(count_reg - CountW'(1));
                        j_next     = count_reg[IdxW-1:0];
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (move)
                begin
                    mem_wdata = rdata_reg;
                    j_next    = j_reg - IdxW'(1);
                    if (j_reg == IdxW'(1))
                        state_next = ST_PLACE;
                    else
                        rd_addr = j_reg - IdxW'(2);
                end
                else
                begin
                    mem_wdata  = key_reg.item.item_value;
                    count_next = count_reg + CountW'(1);
                    state_next = key_reg.item.last_item ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                count_next = count_reg + CountW'(1);
                state_next = key_reg.item.last_item ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.sorted_value = rdata_reg;
                    out_word_next.final_flag   = is_final;
                    out_word_next.truncated    = ovf_reg;
                    if (is_final)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + IdxW'(1);
                        rd_addr = k_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        k_reg        <= k_next;
        key_reg      <= key_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
        rdata_reg <= store[rd_addr];
    end

endmodule

>>> design/insertion_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine_unit
// Streaming insertion sort of signed 32-bit words, up to 64 per run.
// ----------------------------------------------------------------------------
// Input words carry a value and a last marker. Each value is inserted into
// its sorted place as it arrives, ascending or descending as register 0
// (sort_ascending, APB byte address 0) selects at its arrival. A word marked
// last closes the run: all stored values then leave on the output channel in
// order, the final one flagged, every one with truncated set if values were
// dropped because the store was full.
// An insertion moves each stored entry that must make room up by one place, one
// entry at a time; one comparator and the single read port of the store
// walk down the entries. A two-word input queue takes words while an
// insertion or an output run is under way.
// An output run starts after its last word is placed and then gives one word
// per cycle; a stall holds the output register and the run waits.
// Reset empties the queue and the store and sets the ascending order.
// ----------------------------------------------------------------------------
module insertion_sort_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ise_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output ise_pkg::out_word_t out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic          sort_ascending_reg;
    logic          sort_ascending_next;
    logic          cfg_write;
    logic          job_valid;
    logic          job_take;
    ise_pkg::job_t job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == ise_pkg::RegSortAscending);
    assign prdata    = (paddr[2] == ise_pkg::RegSortAscending)
                       ? {31'd0, sort_ascending_reg} : 32'd0;

    always_comb
    begin
        sort_ascending_next = cfg_write ? pwdata[0] : sort_ascending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sort_ascending_reg <= 1'b1;
        else
            sort_ascending_reg <= sort_ascending_next;
    end

    ise_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .sort_ascending (sort_ascending_reg),
        .job_valid      (job_valid),
        .job_take       (job_take),
        .job            (job)
    );

    ise_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for insertion_sort_engine_unit.
// ----------------------------------------------------------------------------
// Words are streamed into the engine in runs closed by a last marker. A model
// of the sorted store, kept in step with every accepted input word, queues
// the words each closed run must produce; output words are compared field by
// field in order. A directed table covers the value extremes, single-word
// runs, equal keys, both orders, a change of order in the middle of a run and
// a write to an unused register address. Random runs follow: mostly short
// ones, plus a run that fills the store exactly and one that overflows it,
// with the order changed between runs over the APB port. Both channels idle
// in random bursts except over the last QuietTail random words.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RandomItems   = 207;
    localparam int          QuietTail     = 40;
    localparam int          SettleCycles  = (ise_pkg::MaxItems + 2) * 3 + 8;
    localparam int          WatchdogLimit = 5000;
    localparam logic [2:0]  OrderAddr     = {ise_pkg::RegSortAscending, 2'b00};
    localparam logic [2:0]  SpareAddr     = {~ise_pkg::RegSortAscending, 2'b00};
    localparam logic signed [31:0] IntMin = 32'sh8000_0000;
    localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

    typedef enum logic [1:0] {CFG_KEEP, CFG_ASC, CFG_DESC, CFG_SPARE} order_step_t;

    typedef struct packed {
        order_step_t        cfg;
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic signed [31:0] expect_value;
    } stim_row_t;

    localparam int DirectedCount = 23;
    localparam stim_row_t DirectedRows [DirectedCount] = '{
        '{CFG_KEEP,   IntMin,  1'b1, 1'b1, IntMin},
        '{CFG_KEEP,   IntMax,  1'b1, 1'b1, IntMax},
        '{CFG_KEEP,   32'sd0,  1'b1, 1'b1, 32'sd0},
        '{CFG_KEEP,   -32'sd1, 1'b1, 1'b1, -32'sd1},
        '{CFG_KEEP,   32'sd5,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   IntMax,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   -32'sd1, 1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   IntMin,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd0,  1'b1, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd7,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd7,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   -32'sd3, 1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd7,  1'b1, 1'b0, 32'sd0},
        '{CFG_DESC,   32'sd3,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   IntMin,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   IntMax,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd3,  1'b1, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd10, 1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd20, 1'b0, 1'b0, 32'sd0},
        '{CFG_ASC,    32'sd15, 1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd5,  1'b1, 1'b0, 32'sd0},
        '{CFG_SPARE,  32'sd1,  1'b0, 1'b0, 32'sd0},
        '{CFG_KEEP,   32'sd2,  1'b1, 1'b0, 32'sd0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ise_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    ise_pkg::out_word_t out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic               word_typed;
    logic signed [31:0] word_expect;

    logic signed [31:0] sort_store [ise_pkg::MaxItems];
    int unsigned        store_fill;
    bit                 overflow_flag;
    bit                 sort_dir;
    ise_pkg::out_word_t expected_sorted_q [$];
    int                 fail_count;
    int                 idle_cycles;
    bit                 quiet;

    insertion_sort_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void insert_and_release(input ise_pkg::in_word_t w, input logic typed,
                                               input logic signed [31:0] typed_value);
        logic signed [31:0] key;
        int                 j;
        ise_pkg::out_word_t res;
        key = w.item_value;
        if (store_fill < ise_pkg::MaxItems)
        begin
            j = store_fill;
            while (j > 0 && (sort_dir ? (sort_store[j - 1] > key) : (key > sort_store[j - 1])))
            begin
                sort_store[j] = sort_store[j - 1];
                j--;
            end
            sort_store[j] = key;
            store_fill++;
        end
        else
            overflow_flag = 1'b1;
        if (!w.last_item)
            return;
        if (typed)
        begin
            res.sorted_value = typed_value;
            res.final_flag   = 1'b1;
            res.truncated    = 1'b0;
            expected_sorted_q.push_back(res);
        end
        else
            for (int k = 0; k < store_fill; k++)
            begin
                res.sorted_value = sort_store[k];
                res.final_flag   = (k == store_fill - 1);
                res.truncated    = overflow_flag;
                expected_sorted_q.push_back(res);
            end
        store_fill    = 0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void check_sorted(input ise_pkg::out_word_t got);
        ise_pkg::out_word_t exp;
        if (expected_sorted_q.size() == 0)
        begin
            $error("unexpected output word: sorted_value %0d", got.sorted_value);
            fail_count++;
            return;
        end
        exp = expected_sorted_q.pop_front();
        if (got.sorted_value !== exp.sorted_value)
        begin
            $error("sorted_value: expected %0d, got %0d", exp.sorted_value, got.sorted_value);
            fail_count++;
        end
        if (got.final_flag !== exp.final_flag)
        begin
            $error("final_flag: expected %0b, got %0b", exp.final_flag, got.final_flag);
            fail_count++;
        end
        if (got.truncated !== exp.truncated)
        begin
            $error("truncated: expected %0b, got %0b", exp.truncated, got.truncated);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                insert_and_release(in_word, word_typed, word_expect);
            if (out_valid && !out_stall)
                check_sorted(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic push_word(input logic signed [31:0] value, input logic last,
                             input logic typed, input logic signed [31:0] expect_value);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_word.item_value    <= value;
        in_word.last_item     <= last;
        word_typed            <= typed;
        word_expect           <= expect_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic settle_block();
        while (expected_sorted_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr && addr == OrderAddr)
            sort_dir = wdata[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic change_order(input order_step_t step);
        logic [31:0] rd;
        settle_block();
        if (step == CFG_SPARE)
            apb_xfer(1'b1, SpareAddr, {31'b0, ~sort_dir}, rd);
        else
            apb_xfer(1'b1, OrderAddr, {31'b0, step == CFG_ASC}, rd);
        apb_xfer(1'b0, OrderAddr, 32'b0, rd);
        if (rd[0] !== sort_dir)
        begin
            $error("sort_ascending: expected %0b, got %0b", sort_dir, rd[0]);
            fail_count++;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return IntMin;
            1:       return IntMax;
            2:       return $signed($urandom_range(0, 6)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int sent;
        int run_len;
        int run_idx;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        word_typed    = 1'b0;
        word_expect   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        store_fill    = 0;
        overflow_flag = 1'b0;
        sort_dir      = 1'b1;
        fail_count    = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DirectedCount; r++)
        begin
            if (DirectedRows[r].cfg != CFG_KEEP)
            begin
                release_input();
                change_order(DirectedRows[r].cfg);
            end
            push_word(DirectedRows[r].value, DirectedRows[r].last,
                      DirectedRows[r].typed, DirectedRows[r].expect_value);
        end

        sent    = 0;
        run_idx = 0;
        while (sent < RandomItems)
        begin
            if (run_idx == 2)
                run_len = ise_pkg::MaxItems;
            else if (run_idx == 5)
                run_len = ise_pkg::MaxItems + 2;
            else
                run_len = $urandom_range(1, 10);
            if (run_idx != 0 && $urandom_range(0, 2) == 0 && sent < RandomItems - QuietTail)
            begin
                release_input();
                change_order($urandom_range(0, 1) ? CFG_ASC : CFG_DESC);
            end
            for (int k = 0; k < run_len; k++)
            begin
                if (sent >= RandomItems - QuietTail)
                    quiet = 1'b1;
                push_word(pick_value(), k == run_len - 1, 1'b0, 32'sd0);
                sent++;
            end
            run_idx++;
        end
        release_input();

        while (expected_sorted_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
